// ===== rtl/core/bpe_pkg.sv =====
// Package for the byte-pair expander: command and status types, result kinds,
// and the text clean-up function used by the back section.
// No dependencies.
package bpe_pkg;

    localparam int PAIR_ENTRIES = 128;
    localparam int TBL_AW       = 7;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TABLE,
        PH_RUN
    } t_phase;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_TEXT,
        OP_END,
        OP_LOAD,
        OP_EXPAND
    } t_op;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EVAL,
        B_FETCH,
        B_POP
    } t_bstate;

    typedef struct packed {
        t_op               op;
        logic              clr;
        logic              hi;
        logic [TBL_AW-1:0] idx;
        logic [7:0]        data;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic bad;
    } t_bstat;

    function automatic logic [7:0] fix_text(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CHAR_CR) begin
            r = CHAR_LF;
        end else if (c == CHAR_TAB) begin
            r = CHAR_SPACE;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/byte_pair_expander.sv =====
// Top level of the byte-pair expander: front section, command queue and back
// section. Depends on bpe_pkg, bpe_front, bpe_queue and bpe_back.
//
//   Channel   Direction  Handshake                    Payload
//   input     in         i_in_valid / o_in_ready      i_data_byte
//   result    out        o_out_valid / i_out_ready    o_out_byte, o_kind, o_last
//
// A header, table, literal or end byte is one transfer into the front section and
// one command for the back section; literal and end bytes give one result each.
// An expanding byte opens each pair with a table read, then a push, and yields
// each text byte with an emit, then a stack read, so the table and stack memory
// read latency sets its pace. The front stops taking bytes until an expansion
// finishes, because its outcome decides the next phase. Reset is synchronous and
// active low and needs no clearing pass: the pair table has one valid bit per
// entry. A stalled result register holds the back section.
module byte_pair_expander #(
    parameter int STACK_DEPTH = 2048,
    parameter int MAX_RUN     = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);
    import bpe_pkg::*;

    // Front to queue: one command per accepted byte.
    logic   push, pop, q_full, q_empty;
    t_cmd   cmd_in, cmd_head;
    // Back to front: completion and outcome of an expansion.
    t_bstat stat;

    bpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .o_in_ready  (o_in_ready),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .i_stat      (stat)
    );

    bpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (cmd_head)
    );

    bpe_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_RUN     (MAX_RUN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (cmd_head),
        .o_pop       (pop),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

endmodule

// ===== rtl/core/bpe_front.sv =====
// Front section: accepts compressed bytes, tracks the stream phase and turns
// each byte into one command for the back section. Depends on bpe_pkg.
module bpe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [7:0]       i_data_byte,
    output logic             o_in_ready,
    input  logic             i_q_full,
    output logic             o_push,
    output bpe_pkg::t_cmd    o_cmd,
    input  bpe_pkg::t_bstat  i_stat
);
    import bpe_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_wait, n_wait;
    logic [7:0] r_left, n_left;
    logic [7:0] r_widx, n_widx;
    logic       acc;

    assign o_in_ready = !r_wait && !i_q_full;
    assign acc        = i_in_valid && o_in_ready;
    assign o_push     = acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_wait  <= 1'b0;
            r_left  <= '0;
            r_widx  <= '0;
        end else begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_left  <= n_left;
            r_widx  <= n_widx;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_wait     = r_wait;
        n_left     = r_left;
        n_widx     = r_widx;
        o_cmd      = '0;
        o_cmd.op   = OP_CLEAR;
        o_cmd.data = i_data_byte;
        o_cmd.idx  = r_widx[7:1];
        o_cmd.hi   = r_widx[0];

        // An expansion may end the stream, so the phase waits for its outcome.
        if (r_wait && i_stat.done) begin
            n_wait  = 1'b0;
            n_phase = i_stat.bad ? PH_HEADER : PH_RUN;
        end

        if (acc) begin
            unique case (r_phase)
                PH_TABLE: begin
                    o_cmd.op = OP_LOAD;
                    n_widx   = r_widx + 8'd1;
                    n_left   = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_RUN;
                    end
                end
                PH_RUN: begin
                    if (i_data_byte == 8'd0) begin
                        o_cmd.op = OP_END;
                        n_phase  = PH_HEADER;
                    end else if (!i_data_byte[7]) begin
                        o_cmd.op = OP_TEXT;
                    end else begin
                        o_cmd.op = OP_EXPAND;
                        n_wait   = 1'b1;
                    end
                end
                default: begin
                    o_cmd.clr = 1'b1;
                    n_widx    = '0;
                    n_left    = '0;
                    if (i_data_byte[7]) begin
                        o_cmd.op = OP_CLEAR;
                        n_left   = {i_data_byte[6:0], 1'b0};
                        n_phase  = (i_data_byte[6:0] != 7'd0) ? PH_TABLE : PH_RUN;
                    end else if (i_data_byte == 8'd0) begin
                        o_cmd.op = OP_END;
                        n_phase  = PH_HEADER;
                    end else begin
                        o_cmd.op = OP_TEXT;
                        n_phase  = PH_RUN;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/bpe_queue.sv =====
// Two-entry command queue between the front and back sections.
// Depends on bpe_pkg.
module bpe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpe_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output bpe_pkg::t_cmd o_head
);
    import bpe_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/bpe_back.sv =====
// Back section: holds the pair table and the expansion stack, runs each
// command and drives the result register. Depends on bpe_pkg.
module bpe_back #(
    parameter int STACK_DEPTH = 2048,
    parameter int MAX_RUN     = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  bpe_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output bpe_pkg::t_bstat  o_stat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_kind,
    output logic             o_last
);
    import bpe_pkg::*;

    localparam int LW = $clog2(STACK_DEPTH);
    localparam int CW = (MAX_RUN > 2) ? $clog2(MAX_RUN) : 1;
    localparam logic [LW-1:0] LVL_LIMIT = LW'(STACK_DEPTH - 2);
    localparam logic [CW-1:0] RUN_LIMIT = CW'(MAX_RUN - 1);

    t_bstate            r_state, n_state;
    logic [7:0]         r_cur, n_cur;
    logic [LW-1:0]      r_lvl, n_lvl;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [7:0]         r_lo, n_lo;

    logic [15:0]        r_tbl_mem [PAIR_ENTRIES];
    logic [PAIR_ENTRIES-1:0] r_tval;
    logic [15:0]        r_tbl_q;
    logic               r_tbl_qv;
    logic [7:0]         r_stk_mem [STACK_DEPTH];
    logic [7:0]         r_stk_q;

    logic               r_ovalid;
    logic [7:0]         r_obyte;
    logic [1:0]         r_okind;
    logic               r_olast;

    logic               out_free, emit, e_last;
    logic [7:0]         e_byte;
    logic [1:0]         e_kind;
    logic               tbl_we, tbl_clr;
    logic [15:0]        tbl_wdata;
    logic [TBL_AW-1:0]  tbl_raddr;
    logic               stk_we;
    logic [LW-1:0]      stk_raddr;
    logic [15:0]        entry;

    assign out_free    = !r_ovalid || i_out_ready;
    assign entry       = r_tbl_qv ? r_tbl_q : 16'h0000;
    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_kind      = r_okind;
    assign o_last      = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
            r_tval   <= '0;
            r_lvl    <= '0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (tbl_clr) begin
                r_tval <= '0;
            end else if (tbl_we) begin
                r_tval[i_cmd.idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_lo  <= n_lo;
        if (emit) begin
            r_obyte <= e_byte;
            r_okind <= e_kind;
            r_olast <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[i_cmd.idx] <= tbl_wdata;
        end
        r_tbl_q  <= r_tbl_mem[tbl_raddr];
        r_tbl_qv <= r_tval[tbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[r_lvl] <= entry[15:8];
        end
        r_stk_q <= r_stk_mem[stk_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_lvl     = r_lvl;
        n_cnt     = r_cnt;
        n_lo      = r_lo;
        o_pop     = 1'b0;
        o_stat    = '0;
        emit      = 1'b0;
        e_byte    = 8'h00;
        e_kind    = KIND_BYTE;
        e_last    = 1'b0;
        tbl_we    = 1'b0;
        tbl_clr   = 1'b0;
        tbl_wdata = {8'h00, i_cmd.data};
        tbl_raddr = r_cur[TBL_AW-1:0];
        stk_we    = 1'b0;
        stk_raddr = r_lvl - LW'(1);

        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_cmd.op)
                        OP_TEXT: begin
                            if (out_free) begin
                                o_pop   = 1'b1;
                                tbl_clr = i_cmd.clr;
                                emit    = 1'b1;
                                e_byte  = fix_text(i_cmd.data);
                                e_last  = 1'b1;
                            end
                        end
                        OP_END: begin
                            if (out_free) begin
                                o_pop   = 1'b1;
                                tbl_clr = i_cmd.clr;
                                emit    = 1'b1;
                                e_kind  = KIND_END;
                                e_last  = 1'b1;
                            end
                        end
                        OP_LOAD: begin
                            o_pop  = 1'b1;
                            tbl_we = 1'b1;
                            if (i_cmd.hi) begin
                                tbl_wdata = {i_cmd.data, r_lo};
                            end else begin
                                n_lo = i_cmd.data;
                            end
                        end
                        OP_EXPAND: begin
                            o_pop   = 1'b1;
                            n_cur   = i_cmd.data;
                            n_lvl   = '0;
                            n_cnt   = '0;
                            n_state = B_EVAL;
                        end
                        default: begin
                            o_pop   = 1'b1;
                            tbl_clr = 1'b1;
                        end
                    endcase
                end
            end
            B_EVAL: begin
                if (r_cur[7]) begin
                    if (r_lvl > LVL_LIMIT) begin
                        if (out_free) begin
                            emit        = 1'b1;
                            e_kind      = KIND_BAD;
                            e_last      = 1'b1;
                            o_stat.done = 1'b1;
                            o_stat.bad  = 1'b1;
                            n_state     = B_IDLE;
                        end
                    end else begin
                        n_state = B_FETCH;
                    end
                end else if (out_free) begin
                    emit = 1'b1;
                    if (r_cnt >= RUN_LIMIT && r_lvl != '0) begin
                        e_kind      = KIND_BAD;
                        e_last      = 1'b1;
                        o_stat.done = 1'b1;
                        o_stat.bad  = 1'b1;
                        n_state     = B_IDLE;
                    end else begin
                        e_byte = fix_text(r_cur);
                        n_cnt  = r_cnt + CW'(1);
                        if (r_lvl == '0) begin
                            e_last      = 1'b1;
                            o_stat.done = 1'b1;
                            n_state     = B_IDLE;
                        end else begin
                            n_lvl   = r_lvl - LW'(1);
                            n_state = B_POP;
                        end
                    end
                end
            end
            B_FETCH: begin
                stk_we  = 1'b1;
                n_lvl   = r_lvl + LW'(1);
                n_cur   = entry[7:0];
                n_state = B_EVAL;
            end
            default: begin
                n_cur   = r_stk_q;
                n_state = B_EVAL;
            end
        endcase
    end

endmodule

// ===== bench/byte_pair_expander_test.sv =====
// Self-checking bench for the byte-pair expander: directed streams, then random
// streams under random sender pacing and receiver stalls. Depends on bpe_pkg and
// byte_pair_expander.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] text;
    logic [1:0] kind;
    logic       last;
} t_decoded;

// Mirror of the expander: it decodes every accepted byte and keeps the decoded
// results in arrival order until the matching result transfer shows up.
class expansion_board;
    int                 depth;
    int                 run_limit;
    logic [15:0]        pairs [0:127];
    logic [7:0]         stack_q [$];
    bpe_pkg::t_phase    phase;
    int                 bytes_left;
    int                 write_index;
    t_decoded           wants [$];
    int                 errors;
    int                 n_text;
    int                 n_end;
    int                 n_bad;

    function new(int stack_depth, int max_run);
        depth     = stack_depth;
        run_limit = max_run;
        clear_pairs();
        phase       = bpe_pkg::PH_HEADER;
        bytes_left  = 0;
        write_index = 0;
        errors      = 0;
        n_text      = 0;
        n_end       = 0;
        n_bad       = 0;
    endfunction

    function void clear_pairs();
        foreach (pairs[i]) pairs[i] = 16'h0000;
    endfunction

    function int pending();
        return wants.size();
    endfunction

    function logic [7:0] clean(logic [7:0] c);
        case (c)
            bpe_pkg::CHAR_CR:  return bpe_pkg::CHAR_LF;
            bpe_pkg::CHAR_TAB: return bpe_pkg::CHAR_SPACE;
            default:           return c;
        endcase
    endfunction

    function void add(logic [7:0] text, logic [1:0] kind);
        t_decoded d;
        d.text = text;
        d.kind = kind;
        d.last = 1'b0;
        wants.push_back(d);
    endfunction

    function void stop_bad();
        stack_q.delete();
        phase = bpe_pkg::PH_HEADER;
        add(8'd0, bpe_pkg::KIND_BAD);
    endfunction

    // Right half goes in first so that the left half is popped first.
    function bit open_pair(logic [7:0] c);
        logic [15:0] e;
        if (stack_q.size() + 2 > depth) return 1'b0;
        e = pairs[c[6:0]];
        stack_q.push_back(e[15:8]);
        stack_q.push_back(e[7:0]);
        return 1'b1;
    endfunction

    function void expand_byte(logic [7:0] b);
        int         produced;
        logic [7:0] c;
        produced = 0;
        stack_q.delete();
        if (!open_pair(b)) begin
            stop_bad();
            return;
        end
        while (stack_q.size() > 0) begin
            c = stack_q.pop_back();
            if (c[7]) begin
                if (!open_pair(c)) begin
                    stop_bad();
                    return;
                end
            end else if (produced >= run_limit - 1 && stack_q.size() > 0) begin
                stop_bad();
                return;
            end else begin
                add(clean(c), bpe_pkg::KIND_BYTE);
                produced++;
            end
        end
    endfunction

    function void note_input(logic [7:0] b);
        int         prior;
        logic [6:0] idx;
        prior = wants.size();
        case (phase)
            bpe_pkg::PH_TABLE: begin
                idx = 7'(write_index >> 1);
                if (write_index % 2 == 1) pairs[idx][15:8] = b;
                else pairs[idx][7:0] = b;
                write_index = (write_index + 1) % 256;
                if (bytes_left > 0) bytes_left--;
                if (bytes_left == 0) phase = bpe_pkg::PH_RUN;
            end
            bpe_pkg::PH_RUN: begin
                if (b == 8'd0) begin
                    add(8'd0, bpe_pkg::KIND_END);
                    phase = bpe_pkg::PH_HEADER;
                end else if (!b[7]) begin
                    add(clean(b), bpe_pkg::KIND_BYTE);
                end else begin
                    expand_byte(b);
                end
            end
            default: begin
                clear_pairs();
                stack_q.delete();
                write_index = 0;
                bytes_left  = 0;
                if (b[7]) begin
                    bytes_left = 2 * int'(b[6:0]);
                    phase = (bytes_left > 0) ? bpe_pkg::PH_TABLE : bpe_pkg::PH_RUN;
                end else if (b == 8'd0) begin
                    add(8'd0, bpe_pkg::KIND_END);
                    phase = bpe_pkg::PH_HEADER;
                end else begin
                    add(clean(b), bpe_pkg::KIND_BYTE);
                    phase = bpe_pkg::PH_RUN;
                end
            end
        endcase
        if (wants.size() > prior) wants[wants.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [7:0] text, logic [1:0] kind, logic last);
        t_decoded w;
        if (wants.size() == 0) begin
            $error("result with nothing expected: out_byte %0d kind %0d last %0d",
                   text, kind, last);
            errors++;
            return;
        end
        w = wants.pop_front();
        if (w.text !== text) begin
            $error("out_byte mismatch: expected %0d, got %0d", w.text, text);
            errors++;
        end
        if (w.kind !== kind) begin
            $error("kind mismatch: expected %0d, got %0d", w.kind, kind);
            errors++;
        end
        if (w.last !== last) begin
            $error("last mismatch: expected %0d, got %0d", w.last, last);
            errors++;
        end
        case (w.kind)
            bpe_pkg::KIND_BYTE: n_text++;
            bpe_pkg::KIND_END:  n_end++;
            default:            n_bad++;
        endcase
    endfunction
endclass

module byte_pair_expander_test;
    import bpe_pkg::*;

    localparam int STACK_DEPTH  = 2048;
    localparam int MAX_RUN      = 64;
    localparam int RANDOM_ITEMS = 480;
    // The slowest legal run stays far below this, even with an item that walks
    // the whole stack before overflowing.
    localparam int CYCLE_LIMIT  = 1000000;

    // Receiver stall patterns; each one holds for a random stretch of cycles.
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_SPARSE,
        DRAIN_BLOCKS
    } t_drain;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic [1:0] o_kind;
    logic       o_last;

    // Handshake and payload as seen at the falling edge before each rising edge.
    // Nothing the bench drives changes between the falling and the rising
    // edge, so these are exactly the values the block acts on at that edge.
    logic       in_take   = 1'b0;
    logic       out_take  = 1'b0;
    logic [7:0] seen_byte = 8'd0;
    logic [1:0] seen_kind = 2'd0;
    logic       seen_last = 1'b0;

    expansion_board board;
    int         cycles     = 0;
    int         fed        = 0;
    int         burst_left = 0;
    t_drain     drain      = DRAIN_FREE;
    int         drain_left = 0;
    int         drain_ct   = 0;

    // Directed opening. The streams in order: a lone zero byte; an empty header
    // followed by a literal, CR, tab, the top literal, a byte that expands
    // through the all-zero table and a zero; a stream that starts with a literal;
    // a three-pair table holding a zero half, a pair that keeps re-expanding
    // itself on the right (too long an expansion) and the top table index; and
    // a pair that re-expands itself on the left until the stack overflows.
    logic [7:0] opening_bytes [$] = '{
        8'd0,
        8'd128, 8'd65, 8'd13, 8'd9, 8'd127, 8'd200, 8'd0,
        8'd13, 8'd1, 8'd0,
        8'd131, 8'd0, 8'd9, 8'd128, 8'd129, 8'd130, 8'd65, 8'd128, 8'd255, 8'd129,
        8'd129, 8'd128, 8'd65, 8'd128
    };

    byte_pair_expander #(
        .STACK_DEPTH(STACK_DEPTH),
        .MAX_RUN    (MAX_RUN)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_data_byte(i_data_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte (o_out_byte),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        in_take   = i_rst_n && i_in_valid && o_in_ready;
        out_take  = i_rst_n && o_out_valid && i_out_ready;
        seen_byte = o_out_byte;
        seen_kind = o_kind;
        seen_last = o_last;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: the stall pattern switches now and then between always
    // ready, coin flips, sparse ready cycles and long ready and stalled blocks.
    always @(posedge i_clk) begin
        if (out_take) begin
            board.check_result(seen_byte, seen_kind, seen_last);
        end
        if (drain_left == 0) begin
            drain      = t_drain'($urandom_range(0, 3));
            drain_left = $urandom_range(20, 120);
        end else begin
            drain_left--;
        end
        drain_ct++;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            case (drain)
                DRAIN_FREE:   i_out_ready <= 1'b1;
                DRAIN_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                DRAIN_SPARSE: i_out_ready <= (drain_ct % 4 == 0);
                default:      i_out_ready <= ((drain_ct / 8) % 2 == 0);
            endcase
        end
    end

    // One byte transfer. The sender works in bursts; between bursts valid
    // drops for a random gap, and now and then a burst follows with no gap.
    // Valid is only lowered for a real gap, so back-to-back bytes keep it high.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!in_take);
        board.note_input(b);
        fed++;
    endtask

    // A text byte, with CR, tab, zero where allowed and the top literal common.
    function automatic logic [7:0] pick_text(input bit zero_ok);
        case ($urandom_range(0, 11))
            0:       return bpe_pkg::CHAR_CR;
            1:       return bpe_pkg::CHAR_TAB;
            2:       return zero_ok ? 8'd0 : 8'd127;
            3:       return 8'd127;
            default: return 8'($urandom_range(1, 127));
        endcase
    endfunction

    // A table half. Most references point to earlier entries or to entries
    // that are never loaded, so expansions terminate; a few arbitrary bytes
    // may close a loop and end in a malformed stop.
    function automatic logic [7:0] pick_half(input int entry, input int loaded);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 8'($urandom_range(0, 255));
        if (r < 45 && entry > 0) return 8'(128 + $urandom_range(0, entry - 1));
        if (r < 55 && loaded < 128) return 8'(128 + $urandom_range(loaded, 127));
        return pick_text(1'b1);
    endfunction

    // A well-formed stream: header, table, a run of literal and pair bytes,
    // and usually a closing zero. Some streams start with a literal instead.
    task automatic send_stream();
        int         pairs_n;
        int         r;
        int         run_len;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            pairs_n = -1;
            send_byte(pick_text(1'b0));
        end else begin
            if (r < 14) pairs_n = 0;
            else if (r < 90) pairs_n = $urandom_range(1, 6);
            else if (r < 98) pairs_n = $urandom_range(7, 24);
            else pairs_n = $urandom_range(100, 127);
            send_byte(8'(128 + pairs_n));
            for (int i = 0; i < pairs_n; i++) begin
                send_byte(pick_half(i, pairs_n));
                send_byte(pick_half(i, pairs_n));
            end
        end
        run_len = $urandom_range(2, 14);
        for (int i = 0; i < run_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) b = pick_text(1'b0);
            else if (r < 90 && pairs_n >= 0) b = 8'(128 + $urandom_range(0, pairs_n));
            else b = 8'($urandom_range(128, 255));
            send_byte(b);
        end
        if ($urandom_range(0, 9) != 0) send_byte(8'd0);
    endtask

    initial begin
        board = new(STACK_DEPTH, MAX_RUN);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

        // Random part: mostly well-formed streams, the rest raw bytes that
        // land in whatever phase the block happens to be in.
        fed = 0;
        while (fed < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_stream();
            end
        end
        i_in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        // Let any stray result show up and be flagged before closing.
        repeat (64) @(posedge i_clk);

        $display("Fed %0d random bytes after the directed streams; checked %0d text,",
                 fed, board.n_text);
        $display("%0d end and %0d malformed results in %0d cycles.",
                 board.n_end, board.n_bad, cycles);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bpe_pkg.sv
rtl/core/bpe_front.sv
rtl/core/bpe_queue.sv
rtl/core/bpe_back.sv
rtl/core/byte_pair_expander.sv
bench/byte_pair_expander_test.sv
